### hw/rtl/segmented_word_memory_assert.svh
// Assertion macros for the segmented word memory.
`ifndef SEGMENTED_WORD_MEMORY_ASSERT_SVH
`define SEGMENTED_WORD_MEMORY_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition that holds on every clock edge outside reset
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
    `SWM_ASSERT(label, (cond), msg)

`endif

### hw/rtl/swm_pkg.sv
// Package: request codes, status codes and default sizes for the segmented word memory.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int SWM_MAX_SEGMENTS  = 256;
    localparam int SWM_SEGMENT_WORDS = 1024;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 8;
    localparam int OFFSET_W = 10;
    localparam int DATA_W   = 32;
    localparam int MLEN_W   = 11;
    localparam int STATUS_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_MAP   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNMAP = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STORE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PROG  = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_ID      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_TOO_LONG   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_UNMAPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RANGE      = 3'd4;
    localparam logic [STATUS_W-1:0] STS_ZERO_UNMAP = 3'd5;

endpackage

`default_nettype wire

### hw/rtl/segmented_word_memory.sv
// Top level: segmented word memory with a request sequencer over one word memory port.
// Each request is registered, decoded, then answered with a registered result; map also
// clears map_length words (one word cleared per cycle), load program copies the source
// words (read then write per word). A request is accepted only when idle and the result slot is free.
// Synchronous active-low reset clears control state only; word store and free-ID stack
// hold no reset value, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "segmented_word_memory_assert.svh"

module segmented_word_memory
    import swm_pkg::*;
#(
    parameter int MAX_SEGMENTS  = SWM_MAX_SEGMENTS,
    parameter int SEGMENT_WORDS = SWM_SEGMENT_WORDS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_we,
    input  wire logic [MLEN_W-1:0]   cfg_wdata,

    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire logic [FUNC_W-1:0]   s_func,
    input  wire logic [ID_W-1:0]     s_segment_id,
    input  wire logic [OFFSET_W-1:0] s_word_offset,
    input  wire logic [DATA_W-1:0]   s_write_data,
    input  wire logic [MLEN_W-1:0]   s_map_length,

    output      logic                m_valid,
    input  wire logic                m_ready,
    output      logic [DATA_W-1:0]   m_read_data,
    output      logic [STATUS_W-1:0] m_status
);

    localparam int SEG_W  = $clog2(MAX_SEGMENTS);
    localparam int OFF_W  = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
    localparam int LEN_W  = $clog2(SEGMENT_WORDS + 1);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W = SEG_W + OFF_W;

    localparam logic [2:0] SQ_IDLE    = 3'd0;
    localparam logic [2:0] SQ_DECODE  = 3'd1;
    localparam logic [2:0] SQ_CLEAR   = 3'd2;
    localparam logic [2:0] SQ_COPY_RD = 3'd3;
    localparam logic [2:0] SQ_COPY_WR = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [FUNC_W-1:0]       req_func_reg;
    logic [ID_W-1:0]         req_id_reg;
    logic [OFFSET_W-1:0]     req_off_reg;
    logic [DATA_W-1:0]       req_data_reg;
    logic [MLEN_W-1:0]       req_mlen_reg;
    logic [SEG_W-1:0]        nid_reg, nid_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        xfer_len_reg, xfer_len_next;
    logic [MAX_SEGMENTS-1:0] mapped_reg, mapped_next;
    logic [CNT_W-1:0]        free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]        fresh_reg, fresh_next;
    logic [LEN_W-1:0]        seg0_len_reg, seg0_len_next;
    logic                    loaded_reg, loaded_next;
    logic                    m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]       m_read_data_reg, m_read_data_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    logic [DATA_W-1:0] word_mem [0:(1 << ADDR_W)-1];
    logic [LEN_W-1:0]  len_mem  [0:MAX_SEGMENTS-1];
    logic [SEG_W-1:0]  stack_mem [0:MAX_SEGMENTS-1];

    logic [DATA_W-1:0] word_rd_reg;
    logic [LEN_W-1:0]  len_rd_reg;
    logic [SEG_W-1:0]  stack_rd_reg;
    logic              mapped_rd_reg;

    logic              wmem_we;
    logic [ADDR_W-1:0] wmem_waddr, wmem_raddr;
    logic [DATA_W-1:0] wmem_wdata;
    logic              lmem_we;
    logic              smem_we;
    logic [CNT_W-1:0]  stack_top;

    logic              accept;
    logic [31:0]       s_id_wide, s_off_wide, req_id_wide, req_off_wide;
    logic [SEG_W-1:0]  s_id_idx, req_id_idx;
    logic [OFF_W-1:0]  s_off_idx, req_off_idx, cnt_idx;
    logic              id_in_range, id_zero, seg_live, off_ok, mlen_ok;
    logic [LEN_W-1:0]  seg_len, map_len, cfg_len, cnt_inc;
    logic [SEG_W-1:0]  nid_new;
    logic              grant;
    logic              done;
    logic              walking;
    logic [DATA_W-1:0] done_rd;
    logic [STATUS_W-1:0] done_st;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == SQ_IDLE) && (!m_valid_reg || m_ready);

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

    assign s_id_wide    = {{(32-ID_W){1'b0}}, s_segment_id};
    assign s_off_wide   = {{(32-OFFSET_W){1'b0}}, s_word_offset};
    assign req_id_wide  = {{(32-ID_W){1'b0}}, req_id_reg};
    assign req_off_wide = {{(32-OFFSET_W){1'b0}}, req_off_reg};
    assign s_id_idx     = s_id_wide[SEG_W-1:0];
    assign s_off_idx    = s_off_wide[OFF_W-1:0];
    assign req_id_idx   = req_id_wide[SEG_W-1:0];
    assign req_off_idx  = req_off_wide[OFF_W-1:0];
    assign cnt_idx      = OFF_W'(cnt_reg);
    assign cnt_inc      = cnt_reg + LEN_W'(1);

    assign id_in_range = req_id_wide < 32'(MAX_SEGMENTS);
    assign id_zero     = (req_id_reg == '0);
    assign seg_live    = id_in_range && mapped_rd_reg;
    assign seg_len     = id_zero ? seg0_len_reg : len_rd_reg;
    assign off_ok      = req_off_wide < 32'(seg_len);
    assign mlen_ok     = 32'(req_mlen_reg) <= 32'(SEGMENT_WORDS);
    assign map_len     = LEN_W'(req_mlen_reg);
    assign cfg_len     = (32'(cfg_wdata) > 32'(SEGMENT_WORDS)) ? LEN_W'(SEGMENT_WORDS)
                                                               : LEN_W'(cfg_wdata);
    assign stack_top   = free_cnt_reg - CNT_W'(1);
    assign walking     = (state_reg == SQ_CLEAR) || (state_reg == SQ_COPY_RD)
                         || (state_reg == SQ_COPY_WR);

    assign wmem_raddr = (state_reg == SQ_COPY_RD) ? {req_id_idx, cnt_idx}
                                                  : {s_id_idx, s_off_idx};

    always_comb begin
        state_next       = state_reg;
        nid_next         = nid_reg;
        cnt_next         = cnt_reg;
        xfer_len_next    = xfer_len_reg;
        mapped_next      = mapped_reg;
        free_cnt_next    = free_cnt_reg;
        fresh_next       = fresh_reg;
        seg0_len_next    = seg0_len_reg;
        loaded_next      = loaded_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_read_data_next = m_read_data_reg;
        m_status_next    = m_status_reg;
        wmem_we          = 1'b0;
        wmem_waddr       = {req_id_idx, req_off_idx};
        wmem_wdata       = req_data_reg;
        lmem_we          = 1'b0;
        smem_we          = 1'b0;
        nid_new          = stack_rd_reg;
        grant            = 1'b0;
        done             = 1'b0;
        done_rd          = '0;
        done_st          = STS_OK;

        case (state_reg)
            SQ_IDLE: begin
                if (accept) begin
                    state_next = SQ_DECODE;
                end
            end
            SQ_DECODE: begin
                case (req_func_reg)
                    FUNC_MAP: begin
                        if (!mlen_ok) begin
                            done    = 1'b1;
                            done_st = STS_TOO_LONG;
                        end else if (free_cnt_reg != '0) begin
                            nid_new       = stack_rd_reg;
                            free_cnt_next = stack_top;
                            grant         = 1'b1;
                        end else if (fresh_reg < CNT_W'(MAX_SEGMENTS)) begin
                            nid_new    = SEG_W'(fresh_reg);
                            fresh_next = fresh_reg + CNT_W'(1);
                            grant      = 1'b1;
                        end else begin
                            done    = 1'b1;
                            done_st = STS_NO_ID;
                        end
                        if (grant) begin
                            mapped_next[nid_new] = 1'b1;
                            lmem_we              = 1'b1;
                            nid_next             = nid_new;
                            cnt_next             = '0;
                            xfer_len_next        = map_len;
                            if (map_len == '0) begin
                                done    = 1'b1;
                                done_rd = {{(DATA_W-SEG_W){1'b0}}, nid_new};
                            end else begin
                                state_next = SQ_CLEAR;
                            end
                        end
                    end
                    FUNC_UNMAP: begin
                        done = 1'b1;
                        if (id_zero) begin
                            done_st = STS_ZERO_UNMAP;
                        end else if (!seg_live) begin
                            done_st = STS_UNMAPPED;
                        end else begin
                            mapped_next[req_id_idx] = 1'b0;
                            if (free_cnt_reg < CNT_W'(MAX_SEGMENTS)) begin
                                smem_we       = 1'b1;
                                free_cnt_next = free_cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    FUNC_LOAD: begin
                        done = 1'b1;
                        if (!seg_live) begin
                            done_st = STS_UNMAPPED;
                        end else if (!off_ok) begin
                            done_st = STS_RANGE;
                        end else begin
                            done_rd = word_rd_reg;
                        end
                    end
                    FUNC_STORE: begin
                        done = 1'b1;
                        if (!seg_live) begin
                            done_st = STS_UNMAPPED;
                        end else if (!off_ok) begin
                            done_st = STS_RANGE;
                        end else begin
                            wmem_we = 1'b1;
                        end
                    end
                    FUNC_PROG: begin
                        if (id_zero) begin
                            done = 1'b1;
                        end else if (!seg_live) begin
                            done    = 1'b1;
                            done_st = STS_UNMAPPED;
                        end else begin
                            seg0_len_next = seg_len;
                            loaded_next   = 1'b1;
                            cnt_next      = '0;
                            xfer_len_next = seg_len;
                            if (seg_len == '0) begin
                                done = 1'b1;
                            end else begin
                                state_next = SQ_COPY_RD;
                            end
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            SQ_CLEAR: begin
                wmem_we    = 1'b1;
                wmem_waddr = {nid_reg, cnt_idx};
                wmem_wdata = '0;
                cnt_next   = cnt_inc;
                if (cnt_inc == xfer_len_reg) begin
                    done    = 1'b1;
                    done_rd = {{(DATA_W-SEG_W){1'b0}}, nid_reg};
                end
            end
            SQ_COPY_RD: begin
                state_next = SQ_COPY_WR;
            end
            SQ_COPY_WR: begin
                wmem_we    = 1'b1;
                wmem_waddr = {{SEG_W{1'b0}}, cnt_idx};
                wmem_wdata = word_rd_reg;
                cnt_next   = cnt_inc;
                if (cnt_inc == xfer_len_reg) begin
                    done = 1'b1;
                end else begin
                    state_next = SQ_COPY_RD;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase

        if (done) begin
            state_next       = SQ_IDLE;
            m_valid_next     = 1'b1;
            m_read_data_next = done_rd;
            m_status_next    = done_st;
        end

        // segment zero follows the register until a program replaces it
        if (cfg_we && !loaded_reg) begin
            seg0_len_next = cfg_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SQ_IDLE;
            mapped_reg   <= MAX_SEGMENTS'(1);
            free_cnt_reg <= '0;
            fresh_reg    <= CNT_W'(1);
            seg0_len_reg <= LEN_W'(SEGMENT_WORDS);
            loaded_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mapped_reg   <= mapped_next;
            free_cnt_reg <= free_cnt_next;
            fresh_reg    <= fresh_next;
            seg0_len_reg <= seg0_len_next;
            loaded_reg   <= loaded_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_func_reg <= s_func;
            req_id_reg   <= s_segment_id;
            req_off_reg  <= s_word_offset;
            req_data_reg <= s_write_data;
            req_mlen_reg <= s_map_length;
        end
        nid_reg         <= nid_next;
        cnt_reg         <= cnt_next;
        xfer_len_reg    <= xfer_len_next;
        m_read_data_reg <= m_read_data_next;
        m_status_reg    <= m_status_next;
        mapped_rd_reg   <= mapped_reg[s_id_idx];
    end

    always_ff @(posedge aclk) begin
        if (wmem_we) begin
            word_mem[wmem_waddr] <= wmem_wdata;
        end
        word_rd_reg <= word_mem[wmem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lmem_we) begin
            len_mem[nid_new] <= map_len;
        end
        len_rd_reg <= len_mem[s_id_idx];
    end

    always_ff @(posedge aclk) begin
        if (smem_we) begin
            stack_mem[free_cnt_reg[SEG_W-1:0]] <= req_id_idx;
        end
        stack_rd_reg <= stack_mem[stack_top[SEG_W-1:0]];
    end

    `SWM_ASSERT(a_accept_decodes, accept |=> (state_reg == SQ_DECODE), "request not decoded")
    `SWM_ASSERT_ALWAYS(a_seg0_mapped, mapped_reg[0], "segment zero lost its mapping")
    `SWM_ASSERT_ALWAYS(a_free_below_fresh, free_cnt_reg < fresh_reg, "free stack too deep")
    `SWM_ASSERT_ALWAYS(a_seg0_len_max, 32'(seg0_len_reg) <= 32'(SEGMENT_WORDS), "seg0 too long")
    `SWM_ASSERT(a_walk_in_length, walking |-> (cnt_reg < xfer_len_reg), "word walk past length")

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for segmented_word_memory: shadow-memory prediction of every response.
`timescale 1ns / 1ps
module tb;
    import swm_pkg::*;

    localparam int NSEG  = SWM_MAX_SEGMENTS;
    localparam int NWORD = SWM_SEGMENT_WORDS;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [ID_W-1:0]     seg;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   wdata;
        logic [MLEN_W-1:0]   mlen;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   rdata;
        logic [STATUS_W-1:0] status;
    } mem_rsp_t;

    typedef struct packed {
        mem_req_t req;
        mem_rsp_t rsp;
    } req_entry_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [MLEN_W-1:0]   cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic [FUNC_W-1:0]   s_func        = '0;
    logic [ID_W-1:0]     s_segment_id  = '0;
    logic [OFFSET_W-1:0] s_word_offset = '0;
    logic [DATA_W-1:0]   s_write_data  = '0;
    logic [MLEN_W-1:0]   s_map_length  = '0;
    logic                m_ready       = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [DATA_W-1:0]   m_read_data;
    logic [STATUS_W-1:0] m_status;

    segmented_word_memory uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_segment_id  (s_segment_id),
        .s_word_offset (s_word_offset),
        .s_write_data  (s_write_data),
        .s_map_length  (s_map_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_status      (m_status)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the memory state
    logic [DATA_W-1:0] sh_words [NSEG*NWORD];
    logic [MLEN_W-1:0] sh_len [NSEG];
    logic              sh_live [NSEG];
    logic [ID_W-1:0]   sh_free [NSEG];
    int unsigned       sh_free_top;
    int unsigned       sh_fresh;
    logic [MLEN_W-1:0] sh_prog_words;
    logic              sh_prog_loaded;
    logic              seg0_written [NWORD];

    req_entry_t  req_backlog [$];
    mem_rsp_t    rsp_due [$];
    int unsigned reqs_queued = 0;
    int unsigned rsp_checked = 0;
    int unsigned errors = 0;
    int unsigned cfg_writes = 0;
    int unsigned func_count [8];
    int unsigned status_count [8];

    function automatic mem_rsp_t serve_request(input mem_req_t r);
        mem_rsp_t    rsp;
        int unsigned nid;
        int unsigned n;
        logic        got_id;
        rsp.rdata  = '0;
        rsp.status = STS_OK;
        got_id     = 1'b0;
        nid        = 0;
        case (r.func)
            FUNC_MAP: begin
                if (r.mlen > NWORD) begin
                    rsp.status = STS_TOO_LONG;
                end else if (sh_free_top > 0) begin
                    sh_free_top--;
                    nid    = 32'(sh_free[sh_free_top]);
                    got_id = 1'b1;
                end else if (sh_fresh < NSEG) begin
                    nid    = sh_fresh;
                    sh_fresh++;
                    got_id = 1'b1;
                end else begin
                    rsp.status = STS_NO_ID;
                end
                if (got_id) begin
                    for (int k = 0; k < NWORD; k++) sh_words[nid*NWORD + k] = '0;
                    sh_len[nid]  = r.mlen;
                    sh_live[nid] = 1'b1;
                    rsp.rdata    = nid;
                end
            end
            FUNC_UNMAP: begin
                if (r.seg == 0) begin
                    rsp.status = STS_ZERO_UNMAP;
                end else if (!sh_live[r.seg]) begin
                    rsp.status = STS_UNMAPPED;
                end else begin
                    sh_live[r.seg] = 1'b0;
                    sh_len[r.seg]  = '0;
                    if (sh_free_top < NSEG) begin
                        sh_free[sh_free_top] = r.seg;
                        sh_free_top++;
                    end
                end
            end
            FUNC_LOAD: begin
                if (!sh_live[r.seg]) rsp.status = STS_UNMAPPED;
                else if (r.off >= sh_len[r.seg]) rsp.status = STS_RANGE;
                else rsp.rdata = sh_words[r.seg*NWORD + r.off];
            end
            FUNC_STORE: begin
                if (!sh_live[r.seg]) begin
                    rsp.status = STS_UNMAPPED;
                end else if (r.off >= sh_len[r.seg]) begin
                    rsp.status = STS_RANGE;
                end else begin
                    sh_words[r.seg*NWORD + r.off] = r.wdata;
                    if (r.seg == 0) seg0_written[r.off] = 1'b1;
                end
            end
            FUNC_PROG: begin
                if (r.seg != 0) begin
                    if (!sh_live[r.seg]) begin
                        rsp.status = STS_UNMAPPED;
                    end else begin
                        n = 32'(sh_len[r.seg]);
                        for (int k = 0; k < n; k++) begin
                            sh_words[k]     = sh_words[r.seg*NWORD + k];
                            seg0_written[k] = 1'b1;
                        end
                        sh_len[0]      = MLEN_W'(n);
                        sh_prog_loaded = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void set_program_words(input logic [MLEN_W-1:0] v);
        sh_prog_words = v;
        if (!sh_prog_loaded) sh_len[0] = (v > NWORD) ? MLEN_W'(NWORD) : v;
    endfunction

    function automatic mem_req_t mk_req(input logic [FUNC_W-1:0] f, input int unsigned seg,
                                        input int unsigned off, input logic [DATA_W-1:0] d,
                                        input int unsigned ml);
        mem_req_t r;
        r.func  = f;
        r.seg   = ID_W'(seg);
        r.off   = OFFSET_W'(off);
        r.wdata = d;
        r.mlen  = MLEN_W'(ml);
        return r;
    endfunction

    function automatic mem_rsp_t queue_request(input mem_req_t r);
        req_entry_t e;
        e.req = r;
        e.rsp = serve_request(r);
        req_backlog.push_back(e);
        reqs_queued++;
        func_count[r.func]++;
        return e.rsp;
    endfunction

    function automatic int pick_live_id();
        int cnt;
        int k;
        cnt = 0;
        for (int i = 1; i < NSEG; i++) if (sh_live[i]) cnt++;
        if (cnt == 0) return -1;
        k = $urandom_range(0, cnt - 1);
        for (int i = 1; i < NSEG; i++) begin
            if (sh_live[i]) begin
                if (k == 0) return i;
                k--;
            end
        end
        return -1;
    endfunction

    function automatic mem_req_t rand_request();
        mem_req_t r;
        int       sel;
        int       id;
        int       w;
        r.func  = FUNC_W'($urandom_range(0, 7));
        r.seg   = ID_W'($urandom);
        r.off   = OFFSET_W'($urandom);
        r.wdata = $urandom;
        r.mlen  = MLEN_W'($urandom);
        sel = $urandom_range(0, 99);
        id  = pick_live_id();
        if (sel < 14) begin
            r.func = FUNC_MAP;
            w = $urandom_range(0, 199);
            // w in 2..11 keeps all 11 random bits: often too long
            if (w < 2) r.mlen = MLEN_W'(NWORD);
            else if (w >= 40) r.mlen = MLEN_W'($urandom_range(0, 6));
            else if (w >= 12) r.mlen = MLEN_W'($urandom_range(0, 64));
        end else if (sel < 24) begin
            r.func = FUNC_UNMAP;
            if (id > 0 && $urandom_range(0, 4) != 0) r.seg = ID_W'(id);
        end else if (sel < 82) begin
            r.func = (sel < 52) ? FUNC_STORE : FUNC_LOAD;
            w = $urandom_range(0, 19);
            if (w < 3) r.seg = '0;
            else if (w < 17 && id > 0) r.seg = ID_W'(id);
            if (w < 17 && sh_len[r.seg] != 0)
                r.off = OFFSET_W'($urandom_range(0, sh_len[r.seg] - 1));
        end else if (sel < 90) begin
            r.func = FUNC_PROG;
            if (id > 0 && $urandom_range(0, 4) != 0) r.seg = ID_W'(id);
            else if ($urandom_range(0, 5) == 0) r.seg = '0;
        end else if (sel < 94) begin
            r.func = FUNC_W'($urandom_range(5, 7));
        end
        // never read a word of segment zero that was never written
        if (r.func == FUNC_LOAD && r.seg == 0 && r.off < sh_len[0] && !seg0_written[r.off])
            r.func = FUNC_STORE;
        return r;
    endfunction

    task automatic wait_drained();
        while (rsp_checked < reqs_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_program_words(input logic [MLEN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        set_program_words(v);
        cfg_writes++;
    endtask

    // request driver: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    mem_rsp_t    cur_rsp;

    always @(posedge aclk) begin
        req_entry_t e;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) rsp_due.push_back(cur_rsp);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    e = req_backlog.pop_front();
                    s_func        <= e.req.func;
                    s_segment_id  <= e.req.seg;
                    s_word_offset <= e.req.off;
                    s_write_data  <= e.req.wdata;
                    s_map_length  <= e.req.mlen;
                    s_valid       <= 1'b1;
                    cur_rsp = e.rsp;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and receiver backpressure
    int unsigned rx_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_tick = 0;

    always @(posedge aclk) begin
        mem_rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rsp_checked++;
                status_count[m_status]++;
                if (rsp_due.size() == 0) begin
                    $error("unexpected response: read_data %h status %0d", m_read_data, m_status);
                    errors++;
                end else begin
                    want = rsp_due.pop_front();
                    if (m_read_data !== want.rdata) begin
                        $error("read_data: expected %h, got %h", want.rdata, m_read_data);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        errors++;
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_tick % 3 == 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        mem_rsp_t rsp;
        int       id;
        for (int i = 0; i < NSEG; i++) begin
            sh_len[i]  = '0;
            sh_live[i] = 1'b0;
        end
        for (int i = 0; i < NWORD; i++) seg0_written[i] = 1'b0;
        for (int i = 0; i < 8; i++) begin
            func_count[i]   = 0;
            status_count[i] = 0;
        end
        sh_live[0]     = 1'b1;
        sh_prog_loaded = 1'b0;
        sh_free_top    = 0;
        sh_fresh       = 1;
        set_program_words(MLEN_W'(NWORD));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset length of segment zero
        void'(queue_request(mk_req(FUNC_STORE, 0, NWORD - 1, 32'hFFFF_FFFF, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 0, NWORD - 1, 0, 0)));
        void'(queue_request(mk_req(FUNC_STORE, 0, 0, 32'h0, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 0, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, NWORD + 1)));
        void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, 2047)));
        void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 1, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_STORE, 1, 0, 32'h1, 0)));
        void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, NWORD)));
        void'(queue_request(mk_req(FUNC_STORE, 2, NWORD - 1, 32'hA5A5_5A5A, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 2, NWORD - 1, 0, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 2, 512, 0, 0)));
        void'(queue_request(mk_req(FUNC_UNMAP, 0, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_UNMAP, 1, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_UNMAP, 1, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_UNMAP, 255, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, 2)));
        void'(queue_request(mk_req(3'd5, 7, 3, 32'h5, 5)));
        void'(queue_request(mk_req(3'd7, 255, 1023, 32'hFFFF_FFFF, 2047)));
        wait_drained();

        write_program_words('0);
        void'(queue_request(mk_req(FUNC_STORE, 0, 0, 32'h7, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 0, NWORD - 1, 0, 0)));
        wait_drained();

        write_program_words(11'h7FF);
        void'(queue_request(mk_req(FUNC_LOAD, 0, NWORD - 1, 0, 0)));
        wait_drained();

        write_program_words(11'd5);
        void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, 3)));
        void'(queue_request(mk_req(FUNC_STORE, 3, 2, 32'h1234_5678, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 200, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_STORE, 200, 0, 32'h9, 0)));
        void'(queue_request(mk_req(FUNC_PROG, 200, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_PROG, 0, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_PROG, 3, 0, 0, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 0, 2, 0, 0)));
        void'(queue_request(mk_req(FUNC_LOAD, 0, 3, 0, 0)));

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2) begin
                // use up every ID, then free some and remap
                do begin
                    rsp = queue_request(mk_req(FUNC_MAP, 0, 0, 0, $urandom_range(0, 2)));
                end while (rsp.status != STS_NO_ID);
                void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, NWORD + 1)));
                repeat (40) begin
                    id = pick_live_id();
                    void'(queue_request(mk_req(FUNC_UNMAP, id, 0, 0, 0)));
                end
                repeat (20) void'(queue_request(mk_req(FUNC_MAP, 0, 0, 0, $urandom_range(0, 8))));
            end else begin
                repeat (250) void'(queue_request(rand_request()));
            end
            wait_drained();
            case (ph)
                0: write_program_words(MLEN_W'(NWORD));
                1: write_program_words(11'd1);
                default: write_program_words(MLEN_W'($urandom_range(0, 2047)));
            endcase
        end
        wait_drained();
        repeat (32) @(posedge aclk);

        if (rsp_due.size() != 0) begin
            $error("%0d responses never arrived", rsp_due.size());
            errors++;
        end
        $display("Ran %0d requests: %0d map, %0d unmap, %0d load, %0d store, %0d program load,",
                 reqs_queued, func_count[FUNC_MAP], func_count[FUNC_UNMAP], func_count[FUNC_LOAD],
                 func_count[FUNC_STORE], func_count[FUNC_PROG]);
        $display("%0d program_words writes; status mix: ok %0d, no id %0d, too long %0d, %s",
                 cfg_writes, status_count[STS_OK], status_count[STS_NO_ID],
                 status_count[STS_TOO_LONG],
                 $sformatf("unmapped %0d, range %0d, zero unmap %0d",
                           status_count[STS_UNMAPPED], status_count[STS_RANGE],
                           status_count[STS_ZERO_UNMAP]));
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
